// File: hdl/gsbu_pkg.sv
`default_nettype none

package gsbu_pkg;

  // Default store depth in bytes.
  localparam int CHUNK_BYTES_DEF = 4096;

  // Field widths, fixed by the interface.
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 12;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 7;
  localparam int FMT_W    = 3;
  localparam int LEN_W    = 13;
  localparam int SAMPLE_W = 64;

  // Longest read or skip; larger counts are clipped to this.
  localparam logic [COUNT_W-1:0] MAX_BITS = 7'd64;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SKIP   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REWIND = 2'd3;

  // Sample format codes; anything above FMT_FLOAT is unknown.
  localparam logic [FMT_W-1:0] FMT_OFFSET  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_TWOS    = 3'd1;
  localparam logic [FMT_W-1:0] FMT_SIGNMAG = 3'd2;
  localparam logic [FMT_W-1:0] FMT_FLOAT   = 3'd3;

  // How the final sample is formed from the shift register.
  typedef enum logic [1:0] {
    KIND_ZERO    = 2'd0,
    KIND_UNIT    = 2'd1,
    KIND_RAW     = 2'd2,
    KIND_SIGNMAG = 2'd3
  } res_kind_t;

  // Control from the sequencer to the bit shifter.
  typedef struct packed {
    logic             shift;
    logic             first;
    logic             bit_in;
    logic [FMT_W-1:0] fmt;
    res_kind_t        kind;
  } shift_ctl_t;

endpackage

`default_nettype wire

// File: hdl/gsbu_store.sv
`default_nettype none

module gsbu_store #(
  parameter int DEPTH = gsbu_pkg::CHUNK_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [gsbu_pkg::BYTE_W-1:0] wr_data,
  input  wire logic                      rd_en,
  input  wire logic [AW-1:0]             rd_addr,
  output logic      [gsbu_pkg::BYTE_W-1:0] rd_data
);
  import gsbu_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hdl/gsbu_bit_shifter.sv
`default_nettype none

module gsbu_bit_shifter (
  input  wire logic                               clk,
  input  wire gsbu_pkg::shift_ctl_t               ctl,
  output logic signed [gsbu_pkg::SAMPLE_W-1:0]    sample
);
  import gsbu_pkg::*;

  logic [SAMPLE_W-1:0] acc_r;
  logic [SAMPLE_W-1:0] acc_nxt;
  logic                sign_r;
  logic [SAMPLE_W-1:0] res;

  // The first bit seeds the whole register so that sign extension falls out
  // of the shifting itself; no variable-width shifter is needed.
  always_comb begin
    if (ctl.first) begin
      case (ctl.fmt)
        FMT_OFFSET:  acc_nxt = {SAMPLE_W{~ctl.bit_in}};
        FMT_TWOS:    acc_nxt = {SAMPLE_W{ctl.bit_in}};
        FMT_SIGNMAG: acc_nxt = '0;
        default:     acc_nxt = {{(SAMPLE_W-1){1'b0}}, ctl.bit_in};
      endcase
    end else begin
      acc_nxt = {acc_r[SAMPLE_W-2:0], ctl.bit_in};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      acc_r <= acc_nxt;
    end
    if (ctl.shift && ctl.first) begin
      sign_r <= ctl.bit_in;
    end
  end

  always_comb begin
    case (ctl.kind)
      KIND_ZERO:    res = '0;
      KIND_UNIT:    res = sign_r ? {SAMPLE_W{1'b1}} : SAMPLE_W'(1);
      KIND_RAW:     res = acc_r;
      KIND_SIGNMAG: res = sign_r ? (SAMPLE_W'(0) - acc_r) : acc_r;
      default:      res = '0;
    endcase
  end

  assign sample = $signed(res);

endmodule

`default_nettype wire

// File: hdl/gnss_sample_bit_unpacker.sv
`default_nettype none

// Channel   Direction  Handshake        Payload
// in_*      input      valid / stall    command, byte_address, load_byte, bit_count,
//                                       sample_format
// out_*     output     valid / stall    sample, is_float, format_error, chunk_done
// cfg_*     input      valid / ready    chunk_length
//
// A load, skip or rewind goes from idle to the done state. A read goes through a fetch
// state for each store byte it touches, each a registered store read, a shift step for
// each bit and then the done state; bits past the store end are zeros and need no fetch.
// rst_n is synchronous and clears the position, the float flag, chunk_length and the
// handshake state; the store itself is not cleared.
// With a result held in the output register under out_stall, one more item is taken
// and worked, and its finished result then waits with in_stall high.
module gnss_sample_bit_unpacker #(
  parameter int CHUNK_BYTES = gsbu_pkg::CHUNK_BYTES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input items
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [gsbu_pkg::CMD_W-1:0]          in_command,
  input  wire logic [gsbu_pkg::ADDR_W-1:0]         in_byte_address,
  input  wire logic [gsbu_pkg::BYTE_W-1:0]         in_load_byte,
  input  wire logic [gsbu_pkg::COUNT_W-1:0]        in_bit_count,
  input  wire logic [gsbu_pkg::FMT_W-1:0]          in_sample_format,
  // results
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [gsbu_pkg::SAMPLE_W-1:0]     out_sample,
  output logic                                     out_is_float,
  output logic                                     out_format_error,
  output logic                                     out_chunk_done,
  // configuration
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [gsbu_pkg::LEN_W-1:0]          cfg_chunk_length
);
  import gsbu_pkg::*;

  // Store address width and byte position width; the position must be able to
  // hold CHUNK_BYTES itself, which is where it saturates.
  localparam int AW  = $clog2(CHUNK_BYTES);
  localparam int BW  = $clog2(CHUNK_BYTES + 1);
  localparam int SW  = BW + 4;
  localparam int LIM = CHUNK_BYTES * 8;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [BW-1:0]      byte_pos_r, byte_pos_nxt;
  logic [2:0]         bit_pos_r, bit_pos_nxt;
  logic               lwf_r, lwf_nxt;
  logic [LEN_W-1:0]   chunk_len_r, chunk_len_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Item payload held while it is worked on; no reset needed.
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               first_r, first_nxt;
  logic [FMT_W-1:0]   fmt_r, fmt_nxt;
  res_kind_t          kind_r, kind_nxt;
  logic               err_r, err_nxt;

  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic               out_is_float_r;
  logic               out_format_error_r;
  logic               out_chunk_done_r;

  logic               in_xfer;
  logic               out_load;
  logic               at_end;
  logic [COUNT_W-1:0] n_eff;
  logic [SW-1:0]      skip_sum;
  logic               mem_we;
  logic               mem_re;
  logic [BYTE_W-1:0]  rd_data;
  logic               cur_bit;
  shift_ctl_t         sh_ctl;
  logic signed [SAMPLE_W-1:0] conv_sample;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Position CHUNK_BYTES (bit 0) is the saturated end of the store: any bit
  // fetched there reads as zero and does not move the position.
  assign at_end = (byte_pos_r == BW'(CHUNK_BYTES));

  assign n_eff = (in_bit_count > MAX_BITS) ? MAX_BITS : in_bit_count;

  // A skip moves the linear bit position in one add and saturates at the end.
  assign skip_sum = SW'({byte_pos_r, bit_pos_r}) + SW'(n_eff);

  // Current bit, MSB first within the byte.
  assign cur_bit = at_end ? 1'b0 : rd_data[~bit_pos_r];

  assign mem_we = in_xfer && (in_command == CMD_LOAD) &&
                  (32'(in_byte_address) < 32'(CHUNK_BYTES));
  assign mem_re = (state_r == ST_FETCH);

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign sh_ctl.shift  = (state_r == ST_SHIFT);
  assign sh_ctl.first  = first_r;
  assign sh_ctl.bit_in = cur_bit;
  assign sh_ctl.fmt    = fmt_r;
  assign sh_ctl.kind   = kind_r;

  gsbu_store #(
    .DEPTH (CHUNK_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (AW'(in_byte_address)),
    .wr_data (in_load_byte),
    .rd_en   (mem_re),
    .rd_addr (byte_pos_r[AW-1:0]),
    .rd_data (rd_data)
  );

  gsbu_bit_shifter u_shifter (
    .clk    (clk),
    .ctl    (sh_ctl),
    .sample (conv_sample)
  );

  always_comb begin
    state_nxt     = state_r;
    byte_pos_nxt  = byte_pos_r;
    bit_pos_nxt   = bit_pos_r;
    lwf_nxt       = lwf_r;
    chunk_len_nxt = chunk_len_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    fmt_nxt       = fmt_r;
    kind_nxt      = kind_r;
    err_nxt       = err_r;

    // Configuration is to be written only while the block is idle; the block does not enforce this.
    if (cfg_valid && cfg_ready) begin
      chunk_len_nxt = cfg_chunk_length;
    end

    // The result register empties when its transfer completes.
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          kind_nxt  = KIND_ZERO;
          err_nxt   = 1'b0;
          state_nxt = ST_DONE;
          case (in_command)
            CMD_READ: begin
              cnt_nxt   = n_eff;
              first_nxt = 1'b1;
              fmt_nxt   = in_sample_format;
              // Only a multi-bit float read leaves the float flag set.
              lwf_nxt   = (n_eff > COUNT_W'(1)) && (in_sample_format == FMT_FLOAT);
              if (n_eff == COUNT_W'(1)) begin
                kind_nxt = KIND_UNIT;
              end else if (n_eff != '0) begin
                if (in_sample_format == FMT_SIGNMAG) begin
                  kind_nxt = KIND_SIGNMAG;
                end else if (in_sample_format > FMT_FLOAT) begin
                  err_nxt = 1'b1;
                end else begin
                  kind_nxt = KIND_RAW;
                end
              end
              if (n_eff != '0) begin
                state_nxt = at_end ? ST_SHIFT : ST_FETCH;
              end
            end
            CMD_SKIP: begin
              if (skip_sum >= SW'(LIM)) begin
                byte_pos_nxt = BW'(CHUNK_BYTES);
                bit_pos_nxt  = '0;
              end else begin
                byte_pos_nxt = skip_sum[BW+2:3];
                bit_pos_nxt  = skip_sum[2:0];
              end
            end
            CMD_REWIND: begin
              byte_pos_nxt = '0;
              bit_pos_nxt  = '0;
            end
            default: begin
              // Load: the store write is made directly from the input port.
            end
          endcase
        end
      end

      ST_FETCH: begin
        // The store read issued here is registered and used from the next cycle.
        state_nxt = ST_SHIFT;
      end

      ST_SHIFT: begin
        first_nxt = 1'b0;
        cnt_nxt   = cnt_r - COUNT_W'(1);
        if (!at_end) begin
          bit_pos_nxt = bit_pos_r + 3'd1;
          if (bit_pos_r == 3'd7) begin
            byte_pos_nxt = byte_pos_r + BW'(1);
          end
        end
        if (cnt_r == COUNT_W'(1)) begin
          state_nxt = ST_DONE;
        end else if (!at_end && (bit_pos_r == 3'd7) &&
                     (byte_pos_r != BW'(CHUNK_BYTES - 1))) begin
          // Crossed into a byte that is still inside the store.
          state_nxt = ST_FETCH;
        end
      end

      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      byte_pos_r  <= '0;
      bit_pos_r   <= '0;
      lwf_r       <= 1'b0;
      chunk_len_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      byte_pos_r  <= byte_pos_nxt;
      bit_pos_r   <= bit_pos_nxt;
      lwf_r       <= lwf_nxt;
      chunk_len_r <= chunk_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    first_r <= first_nxt;
    fmt_r   <= fmt_nxt;
    kind_r  <= kind_nxt;
    err_r   <= err_nxt;
    if (out_load) begin
      out_sample_r       <= conv_sample;
      out_is_float_r     <= lwf_r;
      out_format_error_r <= err_r;
      out_chunk_done_r   <= (32'(byte_pos_r) == 32'(chunk_len_r));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_is_float     = out_is_float_r;
  assign out_format_error = out_format_error_r;
  assign out_chunk_done   = out_chunk_done_r;

  // The position never passes the saturated end of the store.
  assert property (@(posedge clk) disable iff (!rst_n)
    (32'(byte_pos_r) <= 32'(CHUNK_BYTES)) && (!at_end || (bit_pos_r == 3'd0)))
    else $error("byte position beyond store end");

  // A store read is never issued at the saturated end.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> !at_end)
    else $error("store fetch at end of store");

  // Every accepted item keeps the input stalled on the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input accepted while an item is still in progress");

  // A shift step always has bits left to take.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (cnt_r != '0))
    else $error("bit shift with no bits remaining");

  // An unknown format never produces a non-zero sample.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && err_r) |-> (kind_r == KIND_ZERO))
    else $error("format error with a non-zero sample kind");

endmodule

`default_nettype wire

// File: tb/tb_gnss_sample_bit_unpacker.sv
module tb_gnss_sample_bit_unpacker;
  timeunit 1ns;
  timeprecision 1ps;

  import gsbu_pkg::*;

  // The store has its full default size. A walk crosses most of it with clipped
  // long skips and then reads and skips through the last stretch into the end,
  // so saturation and zero fill past the end are exercised. With a 12-bit
  // address field every load lands inside the store.
  localparam int STORE_BYTES = CHUNK_BYTES_DEF;
  localparam int LOCAL_BYTES = 256;
  localparam int NEAR_END_BYTES = 32;
  localparam int MAX_CHUNK_LEN = 4096;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 100;

  // Format codes above the float code are all unknown to the block.
  localparam logic [FMT_W-1:0] FMT_BAD_FIRST = FMT_FLOAT + 3'd1;
  localparam logic [FMT_W-1:0] FMT_BAD_LAST = 3'd7;

  // Bytes loaded by the directed test, first byte in the top eight bits.
  localparam logic [63:0] DIRECTED_BYTES = 64'hA53CFF00807F5AC3;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                is_float;
    logic                format_error;
    logic                chunk_done;
  } unpack_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command = CMD_LOAD;
  logic [ADDR_W-1:0]   in_byte_address = '0;
  logic [BYTE_W-1:0]   in_load_byte = '0;
  logic [COUNT_W-1:0]  in_bit_count = '0;
  logic [FMT_W-1:0]    in_sample_format = FMT_OFFSET;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_sample;
  logic                out_is_float;
  logic                out_format_error;
  logic                out_chunk_done;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LEN_W-1:0]    cfg_chunk_length = '0;

  // Our own image of the block's state, advanced once per accepted transfer.
  logic [7:0] store_image [STORE_BYTES];
  bit         loaded [STORE_BYTES] = '{default: 1'b0};
  int         pos_byte = 0;
  int         pos_bit = 0;
  logic       float_flag = 1'b0;
  int         model_len = 0;

  unpack_result_t expected_samples [$];
  unpack_result_t want;

  // Idling control. While calm_left is non-zero neither side idles, which gives
  // back-to-back stretches even in the phases with heavy idling.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int calm_left = 0;

  int cycle_count = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int loads_sent = 0;
  int reads_sent = 0;
  int skips_sent = 0;
  int rewinds_sent = 0;
  int length_writes = 0;
  int end_walks = 0;

  gnss_sample_bit_unpacker #(
    .CHUNK_BYTES(STORE_BYTES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_byte_address  (in_byte_address),
    .in_load_byte     (in_load_byte),
    .in_bit_count     (in_bit_count),
    .in_sample_format (in_sample_format),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_is_float     (out_is_float),
    .out_format_error (out_format_error),
    .out_chunk_done   (out_chunk_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_chunk_length (cfg_chunk_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The cycle counter doubles as the watchdog for a hung handshake.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped after %0d cycles with %0d results outstanding", cycle_count,
             expected_samples.size());
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (calm_left != 0) begin
      calm_left <= calm_left - 1;
    end else if ($urandom_range(0, 63) == 0) begin
      calm_left <= $urandom_range(10, 40);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("error: %s", msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [SAMPLE_W-1:0] got,
                             input logic [SAMPLE_W-1:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("result %0d: %s is %h, expected %h", results_checked, name,
                                got, exp_val));
    end
  endtask

  // Result side: every output transfer is compared with the oldest prediction.
  // The stall for the next cycle is chosen here, independently of out_valid.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_checked));
      end else begin
        want = expected_samples.pop_front();
        check_field("sample", out_sample, want.sample);
        check_field("is_float", SAMPLE_W'(out_is_float), SAMPLE_W'(want.is_float));
        check_field("format_error", SAMPLE_W'(out_format_error),
                    SAMPLE_W'(want.format_error));
        check_field("chunk_done", SAMPLE_W'(out_chunk_done), SAMPLE_W'(want.chunk_done));
      end
      results_checked++;
    end
    out_stall <= (calm_left == 0) && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Next bit of the walk, MSB first. At the store end the position is pinned to
  // the end byte, bit zero, and zeros are returned.
  function automatic logic take_bit();
    logic b;
    if (pos_byte >= STORE_BYTES) begin
      pos_byte = STORE_BYTES;
      pos_bit = 0;
      return 1'b0;
    end
    b = store_image[pos_byte][7 - pos_bit];
    pos_bit++;
    if (pos_bit == 8) begin
      pos_bit = 0;
      pos_byte++;
    end
    return b;
  endfunction

  function automatic logic [SAMPLE_W-1:0] extend_sign(input logic [SAMPLE_W-1:0] v, input int n);
    if (n < SAMPLE_W && v[n-1]) begin
      v = v | ({SAMPLE_W{1'b1}} << n);
    end
    return v;
  endfunction

  // Works out the one result of a transfer and moves the state image on.
  function automatic unpack_result_t predict_unpack(input logic [CMD_W-1:0] cmd,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [BYTE_W-1:0] data,
                                                    input logic [COUNT_W-1:0] count,
                                                    input logic [FMT_W-1:0] fmt);
    unpack_result_t r;
    int n;
    int i;
    logic [SAMPLE_W-1:0] raw;
    logic [SAMPLE_W-1:0] top;
    r.sample = '0;
    r.format_error = 1'b0;
    n = (count > MAX_BITS) ? int'(MAX_BITS) : int'(count);
    case (cmd)
      CMD_LOAD: begin
        loads_sent++;
        if (int'(addr) < STORE_BYTES) begin
          store_image[addr] = data;
          loaded[addr] = 1'b1;
        end
      end
      CMD_READ: begin
        reads_sent++;
        float_flag = 1'b0;
        raw = '0;
        for (i = 0; i < n; i++) begin
          raw = {raw[SAMPLE_W-2:0], take_bit()};
        end
        // A single bit is a sign on its own, whatever format is asked for.
        if (n == 1) begin
          r.sample = raw[0] ? {SAMPLE_W{1'b1}} : 64'd1;
        end else if (n > 1) begin
          top = 64'd1 << (n - 1);
          case (fmt)
            FMT_OFFSET: r.sample = extend_sign(raw ^ top, n);
            FMT_TWOS: r.sample = extend_sign(raw, n);
            FMT_SIGNMAG: r.sample = ((raw & top) != 0) ? 64'd0 - (raw - top) : raw;
            FMT_FLOAT: begin
              float_flag = 1'b1;
              r.sample = raw;
            end
            default: r.format_error = 1'b1;
          endcase
        end
      end
      CMD_SKIP: begin
        skips_sent++;
        for (i = 0; i < n; i++) begin
          void'(take_bit());
        end
      end
      CMD_REWIND: begin
        rewinds_sent++;
        pos_byte = 0;
        pos_bit = 0;
      end
      default: begin
      end
    endcase
    r.is_float = float_flag;
    r.chunk_done = (pos_byte == model_len);
    return r;
  endfunction

  // Sends one input transfer, idling first at random. Valid is held until the
  // block takes the item, and the payload does not move while it is stalled.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] data, input logic [COUNT_W-1:0] count,
                           input logic [FMT_W-1:0] fmt);
    while (calm_left == 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_byte_address <= addr;
    in_load_byte <= data;
    in_bit_count <= count;
    in_sample_format <= fmt;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    expected_samples.push_back(predict_unpack(cmd, addr, data, count, fmt));
  endtask

  // A read never touches a store byte that has not been written: any such byte
  // in the span of the read is loaded with random data first.
  task automatic issue_read(input logic [COUNT_W-1:0] count, input logic [FMT_W-1:0] fmt);
    int n;
    int b;
    int last;
    n = (count > MAX_BITS) ? int'(MAX_BITS) : int'(count);
    if (n != 0 && pos_byte < STORE_BYTES) begin
      last = pos_byte + (pos_bit + n - 1) / 8;
      if (last > STORE_BYTES - 1) begin
        last = STORE_BYTES - 1;
      end
      for (b = pos_byte; b <= last; b++) begin
        if (!loaded[b]) begin
          send_item(CMD_LOAD, ADDR_W'(b), BYTE_W'($urandom_range(0, 255)),
                    COUNT_W'($urandom_range(0, 127)), FMT_W'($urandom_range(0, 7)));
        end
      end
    end
    send_item(CMD_READ, ADDR_W'($urandom_range(0, 4095)), BYTE_W'($urandom_range(0, 255)),
              count, fmt);
  endtask

  task automatic wait_for_results();
    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // The length register is only written with the block idle: no transfer in
  // flight and every predicted result already taken.
  task automatic set_chunk_length(input int len);
    in_valid <= 1'b0;
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_chunk_length <= len[LEN_W-1:0];
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    model_len = len;
    length_writes++;
  endtask

  function automatic logic [COUNT_W-1:0] pick_bit_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return COUNT_W'($urandom_range(1, 8));
    end else if (r < 85) begin
      return COUNT_W'($urandom_range(9, 64));
    end else if (r < 92) begin
      return $urandom_range(0, 1) ? MAX_BITS : 7'd0;
    end
    return COUNT_W'($urandom_range(65, 127));
  endfunction

  function automatic logic [FMT_W-1:0] pick_format();
    if ($urandom_range(0, 99) < 85) begin
      return FMT_W'($urandom_range(FMT_OFFSET, FMT_FLOAT));
    end
    return FMT_W'($urandom_range(FMT_BAD_FIRST, FMT_BAD_LAST));
  endfunction

  function automatic int pick_chunk_length();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return MAX_CHUNK_LEN;
      2: return MAX_CHUNK_LEN - 1;
      3: return LOCAL_BYTES;
      4: return $urandom_range(0, MAX_CHUNK_LEN);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // Corners by hand: every command, each format, one-bit and zero-bit reads,
  // clipped counts, a load to the top address and the float flag across a rewind.
  task automatic test_directed_corners();
    int i;
    set_chunk_length(3);
    for (i = 0; i < 8; i++) begin
      send_item(CMD_LOAD, ADDR_W'(i), DIRECTED_BYTES[63 - 8 * i -: 8], '0, FMT_OFFSET);
    end
    // The top of the address field is the last byte of the store.
    send_item(CMD_LOAD, {ADDR_W{1'b1}}, 8'hEE, '0, FMT_OFFSET);
    issue_read(7'd1, FMT_BAD_LAST);
    issue_read(7'd1, FMT_FLOAT);
    issue_read(7'd0, FMT_FLOAT);
    issue_read(7'd6, FMT_OFFSET);
    issue_read(7'd8, FMT_TWOS);
    issue_read(7'd8, FMT_SIGNMAG);
    issue_read(7'd8, FMT_FLOAT);
    send_item(CMD_SKIP, '0, '0, 7'd0, FMT_OFFSET);
    // The float flag survives a rewind.
    send_item(CMD_REWIND, '0, '0, '0, FMT_OFFSET);
    issue_read(MAX_BITS, FMT_TWOS);
    send_item(CMD_REWIND, '0, '0, '0, FMT_OFFSET);
    issue_read(7'd127, FMT_SIGNMAG);
    send_item(CMD_REWIND, '0, '0, '0, FMT_OFFSET);
    issue_read(MAX_BITS, FMT_OFFSET);
    send_item(CMD_REWIND, '0, '0, '0, FMT_OFFSET);
    issue_read(7'd4, FMT_BAD_FIRST);
    send_item(CMD_SKIP, '0, '0, 7'd100, FMT_OFFSET);
  endtask

  // Walks from the chunk start past the end of the store, then reads beyond it,
  // where only zeros come back. Clipped skips cross most of the store eight bytes
  // at a time; the last stretch mixes long reads and skips.
  task automatic test_store_end();
    int i;
    set_chunk_length(STORE_BYTES);
    send_item(CMD_REWIND, ADDR_W'($urandom_range(0, 4095)), BYTE_W'($urandom_range(0, 255)),
              COUNT_W'($urandom_range(0, 127)), FMT_W'($urandom_range(0, 7)));
    while (pos_byte < STORE_BYTES - NEAR_END_BYTES) begin
      send_item(CMD_SKIP, ADDR_W'($urandom_range(0, 4095)), BYTE_W'($urandom_range(0, 255)),
                COUNT_W'($urandom_range(64, 127)), FMT_W'($urandom_range(0, 7)));
    end
    while (pos_byte < STORE_BYTES) begin
      if ($urandom_range(0, 1)) begin
        issue_read(COUNT_W'($urandom_range(33, 127)), FMT_W'($urandom_range(0, 7)));
      end else begin
        send_item(CMD_SKIP, ADDR_W'($urandom_range(0, 4095)), BYTE_W'($urandom_range(0, 255)),
                  COUNT_W'($urandom_range(33, 127)), FMT_W'($urandom_range(0, 7)));
      end
    end
    end_walks++;
    for (i = 0; i < 4; i++) begin
      issue_read(pick_bit_count(), FMT_W'($urandom_range(0, 7)));
    end
    send_item(CMD_SKIP, ADDR_W'($urandom_range(0, 4095)), BYTE_W'($urandom_range(0, 255)),
              MAX_BITS, FMT_W'($urandom_range(0, 7)));
  endtask

  // Mostly reads and skips over loaded data, with loads, rewinds and stray
  // field values mixed in. The chunk length moves every few dozen transfers.
  task automatic test_random_traffic(input int target);
    int since_cfg;
    int pick;
    logic [ADDR_W-1:0] addr;
    since_cfg = 0;
    while (items_sent < target) begin
      if (since_cfg >= 70) begin
        set_chunk_length(pick_chunk_length());
        since_cfg = 0;
      end
      pick = $urandom_range(0, 99);
      addr = ($urandom_range(0, 99) < 80) ? ADDR_W'($urandom_range(0, LOCAL_BYTES - 1))
                                           : ADDR_W'($urandom_range(0, STORE_BYTES - 1));
      if (pick < 16) begin
        send_item(CMD_LOAD, addr, BYTE_W'($urandom_range(0, 255)), pick_bit_count(),
                  pick_format());
      end else if (pick < 66) begin
        issue_read(pick_bit_count(), pick_format());
      end else if (pick < 90) begin
        send_item(CMD_SKIP, addr, BYTE_W'($urandom_range(0, 255)), pick_bit_count(),
                  pick_format());
      end else begin
        send_item(CMD_REWIND, addr, BYTE_W'($urandom_range(0, 255)), pick_bit_count(),
                  pick_format());
      end
      since_cfg++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 34;
    recv_idle_pct = 85;
    test_directed_corners();
    test_store_end();
    test_random_traffic(680);

    // The other way round.
    send_idle_pct = 85;
    recv_idle_pct = 34;
    set_chunk_length(0);
    test_random_traffic(820);

    // Neither side idles.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_chunk_length(MAX_CHUNK_LEN);
    test_random_traffic(950);

    in_valid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d input transfers: %0d loads, %0d reads, %0d skips, %0d rewinds", items_sent,
             loads_sent, reads_sent, skips_sent, rewinds_sent);
    $display("%0d results checked over %0d chunk-length settings, %0d walks to the store end",
             results_checked, length_writes, end_walks);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
